// ===== src/cqfp_pkg.sv =====
// ----------------------------------------------------------------------------
// cqfp_pkg
// Shared codes, key tables and character classes for the callback query
// field parser.
// ----------------------------------------------------------------------------
package cqfp_pkg;

	// field tags
	localparam logic [1:0] FIELD_ERROR = 2'd0;
	localparam logic [1:0] FIELD_CODE  = 2'd1;
	localparam logic [1:0] FIELD_STATE = 2'd2;
	localparam logic [1:0] FIELD_NONE  = 2'd3;

	// verdict codes
	localparam logic [1:0] STATUS_OK      = 2'd0;
	localparam logic [1:0] STATUS_INVALID = 2'd1;
	localparam logic [1:0] STATUS_IDP     = 2'd2;

	// pair phase codes
	localparam logic [1:0] PHASE_KEY   = 2'd0;
	localparam logic [1:0] PHASE_VALUE = 2'd1;

	// percent escape stages
	localparam logic [1:0] ESC_IDLE = 2'd0;
	localparam logic [1:0] ESC_HIGH = 2'd1;
	localparam logic [1:0] ESC_LOW  = 2'd2;

	// special bytes
	localparam logic [7:0] CHAR_AMP     = 8'h26;
	localparam logic [7:0] CHAR_EQ      = 8'h3D;
	localparam logic [7:0] CHAR_PERCENT = 8'h25;
	localparam logic [7:0] CHAR_PLUS    = 8'h2B;
	localparam logic [7:0] CHAR_SPACE   = 8'h20;
	localparam logic [7:0] CHAR_DEL     = 8'h7F;

	localparam logic [2:0] KEY_POS_MAX = 3'd7;

	// length of each key text
	function automatic logic [2:0] key_len(input logic [1:0] k);
		case (k)
			FIELD_ERROR: key_len = 3'd5;
			FIELD_CODE:  key_len = 3'd4;
			FIELD_STATE: key_len = 3'd5;
			default:     key_len = 3'd0;
		endcase
	endfunction

	// character of a key text at a position
	function automatic logic [7:0] key_char(input logic [1:0] k, input logic [2:0] pos);
		logic [39:0] txt;
		case (k)
			FIELD_ERROR: txt = "error";
			FIELD_CODE:  txt = {"code", 8'h00};
			FIELD_STATE: txt = "state";
			default:     txt = '0;
		endcase
		case (pos)
			3'd0:    key_char = txt[39:32];
			3'd1:    key_char = txt[31:24];
			3'd2:    key_char = txt[23:16];
			3'd3:    key_char = txt[15:8];
			3'd4:    key_char = txt[7:0];
			default: key_char = 8'h00;
		endcase
	endfunction

	// hex digit value, 16 when not a hex digit
	function automatic logic [4:0] hex_digit(input logic [7:0] c);
		if (c >= 8'h30 && c <= 8'h39) begin
			hex_digit = {1'b0, c[3:0]};
		end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
			hex_digit = {1'b0, c[3:0] + 4'd9};
		end else begin
			hex_digit = 5'd16;
		end
	endfunction

	// base64url alphabet
	function automatic logic b64url_char(input logic [7:0] c);
		b64url_char = (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A) ||
			(c >= 8'h30 && c <= 8'h39) || c == 8'h2D || c == 8'h5F;
	endfunction

endpackage

// ===== src/cqfp_in_if.sv =====
// ----------------------------------------------------------------------------
// cqfp_in_if
// Query byte channel: one beat per query byte or end marker.
// ----------------------------------------------------------------------------
interface cqfp_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       byte_present;
	logic       last_byte;

	modport source (output valid, output in_byte, output byte_present, output last_byte,
		input ready);
	modport sink (input valid, input in_byte, input byte_present, input last_byte,
		output ready);
endinterface

// ===== src/cqfp_out_if.sv =====
// ----------------------------------------------------------------------------
// cqfp_out_if
// Result channel: decoded value bytes and the end-of-query verdict.
// ----------------------------------------------------------------------------
interface cqfp_out_if;
	logic       valid;
	logic       ready;
	logic       value_valid;
	logic [7:0] value_byte;
	logic [1:0] value_field;
	logic       done_res;
	logic [1:0] status;
	logic       error_text_usable;

	modport source (output valid, output value_valid, output value_byte,
		output value_field, output done_res, output status, output error_text_usable,
		input ready);
	modport sink (input valid, input value_valid, input value_byte,
		input value_field, input done_res, input status, input error_text_usable,
		output ready);
endinterface

// ===== src/callback_query_field_parser.sv =====
// ----------------------------------------------------------------------------
// callback_query_field_parser
// Streaming form-urlencoded parser for the error, code and state fields of
// a login callback query.
// ----------------------------------------------------------------------------
// Usage: the sender pushes one beat per query byte on in_ch; last_byte marks
// the final beat of a query, and a beat with byte_present low only carries
// that end marker (an empty query). Each decoded byte of a matched value
// leaves on out_ch tagged with its field; the final beat of a query yields a
// result with done_res high and the verdict in status, and error_text_usable
// when the identity provider sent a clean error text. Beats that produce
// nothing (key bytes, '&', escape lead-ins, bad values) give no result.
// Each accepted beat sits in the input register; the decode logic loads its
// result into the result register when the beat advances, and out_ch shows
// the result register.
// Throughput: one beat per cycle, with the parse state registers updated as
// each beat advances; the block keeps taking beats while out_ch is ready.
// When the receiver stalls, the result register holds and one more beat
// waits in the input register; then in_ch.ready drops.
// Reset: arst_n clears all parse state and both registers go empty; after
// each final beat the parse state returns to its reset values.
// ----------------------------------------------------------------------------
module callback_query_field_parser #(
	parameter int CODE_MAX_LEN  = 1024,
	parameter int ERROR_MAX_LEN = 128,
	parameter int SECRET_LEN    = 43
) (
	input logic       clk,
	input logic       arst_n,
	cqfp_in_if.sink   in_ch,
	cqfp_out_if.source out_ch
);
	import cqfp_pkg::*;

	localparam int ERR_LW  = $clog2(ERROR_MAX_LEN + 1);
	localparam int CODE_LW = $clog2(CODE_MAX_LEN + 1);
	localparam int ST_LW   = $clog2(SECRET_LEN + 1);

	// input stage
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       present_s1;
	logic       last_s1;
	logic       advance;

	// parse state
	logic [1:0]         pair_phase_q;
	logic [2:0]         key_pos_q;
	logic [2:0]         key_match_q;
	logic [1:0]         active_field_q;
	logic [1:0]         esc_q;
	logic [3:0]         high_nibble_q;
	logic [2:0]         field_found_q;
	logic [2:0]         field_bad_q;
	logic [ERR_LW-1:0]  err_len_q;
	logic [CODE_LW-1:0] code_len_q;
	logic [ST_LW-1:0]   state_len_q;
	logic               state_chars_ok_q;

	// next state
	logic [1:0]         pair_phase_d;
	logic [2:0]         key_pos_d;
	logic [2:0]         key_match_d;
	logic [1:0]         active_field_d;
	logic [1:0]         esc_d;
	logic [3:0]         high_nibble_d;
	logic [2:0]         field_found_d;
	logic [2:0]         field_bad_d;
	logic [ERR_LW-1:0]  err_len_d;
	logic [CODE_LW-1:0] code_len_d;
	logic [ST_LW-1:0]   state_len_d;
	logic               state_chars_ok_d;

	// result
	logic       has_result;
	logic       emit;
	logic [7:0] emit_byte;
	logic [1:0] emit_field;
	logic [1:0] status_d;
	logic       usable_d;

	// result register
	logic       out_valid_q;
	logic       value_valid_q;
	logic [7:0] value_byte_q;
	logic [1:0] value_field_q;
	logic       done_q;
	logic [1:0] status_q;
	logic       usable_q;

	// handshake control
	assign advance     = valid_s1 && (!out_valid_q || out_ch.ready);
	assign in_ch.ready = !valid_s1 || advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			valid_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.ready && in_ch.valid) begin
			byte_s1    <= in_ch.in_byte;
			present_s1 <= in_ch.byte_present;
			last_s1    <= in_ch.last_byte;
		end
	end

	// decode of one beat against the running parse state
	always_comb begin
		logic [2:0] act_mask;
		logic [2:0] eq_mask;
		logic [1:0] match_f;
		logic [4:0] hex_v;
		logic       dec_valid;
		logic [7:0] dec_c;
		logic       len_full;
		logic       code_ok;
		logic       state_ok;

		pair_phase_d     = pair_phase_q;
		key_pos_d        = key_pos_q;
		key_match_d      = key_match_q;
		active_field_d   = active_field_q;
		esc_d            = esc_q;
		high_nibble_d    = high_nibble_q;
		field_found_d    = field_found_q;
		field_bad_d      = field_bad_q;
		err_len_d        = err_len_q;
		code_len_d       = code_len_q;
		state_len_d      = state_len_q;
		state_chars_ok_d = state_chars_ok_q;
		emit             = 1'b0;
		emit_byte        = 8'h00;
		emit_field       = FIELD_ERROR;
		status_d         = STATUS_OK;
		usable_d         = 1'b0;
		dec_valid        = 1'b0;
		dec_c            = 8'h00;
		match_f          = FIELD_NONE;
		eq_mask          = '0;
		len_full         = 1'b0;
		code_ok          = 1'b0;
		state_ok         = 1'b0;
		hex_v            = hex_digit(byte_s1);

		// one-hot of the active field, empty for no field
		act_mask = (active_field_q == FIELD_NONE) ? 3'b000 : (3'b001 << active_field_q);

		if (present_s1) begin
			if (byte_s1 == CHAR_AMP) begin
				// pair separator: cut-short escape spoils the value
				if (pair_phase_q == PHASE_VALUE && esc_q != ESC_IDLE) begin
					field_bad_d = field_bad_d | act_mask;
				end
				pair_phase_d   = PHASE_KEY;
				key_pos_d      = '0;
				key_match_d    = 3'b111;
				active_field_d = FIELD_NONE;
				esc_d          = ESC_IDLE;
				high_nibble_d  = '0;
			end else if (pair_phase_q == PHASE_KEY) begin
				if (byte_s1 == CHAR_EQ) begin
					// end of key: pick the matched field
					for (int k = 0; k < 3; k++) begin
						if (key_match_q[k] && key_pos_q == key_len(2'(k))) begin
							match_f = 2'(k);
						end
					end
					if (match_f != FIELD_NONE) begin
						eq_mask       = 3'b001 << match_f;
						field_bad_d   = field_bad_d | (field_found_q & eq_mask);
						field_found_d = field_found_q | eq_mask;
					end
					active_field_d = match_f;
					pair_phase_d   = PHASE_VALUE;
					esc_d          = ESC_IDLE;
				end else begin
					// key byte: narrow the candidate keys
					for (int k = 0; k < 3; k++) begin
						if (key_pos_q >= key_len(2'(k)) ||
							key_char(2'(k), key_pos_q) != byte_s1) begin
							key_match_d[k] = 1'b0;
						end
					end
					if (key_pos_q < KEY_POS_MAX) begin
						key_pos_d = key_pos_q + 3'd1;
					end
				end
			end else if ((act_mask & ~field_bad_q) != 3'b000) begin
				// value byte of a live field
				if (esc_q == ESC_HIGH) begin
					if (hex_v[4]) begin
						field_bad_d = field_bad_d | act_mask;
						esc_d       = ESC_IDLE;
					end else begin
						high_nibble_d = hex_v[3:0];
						esc_d         = ESC_LOW;
					end
				end else if (esc_q == ESC_LOW) begin
					esc_d = ESC_IDLE;
					if (hex_v[4]) begin
						field_bad_d = field_bad_d | act_mask;
					end else begin
						dec_valid = 1'b1;
						dec_c     = {high_nibble_q, hex_v[3:0]};
					end
				end else if (byte_s1 == CHAR_PERCENT) begin
					esc_d = ESC_HIGH;
				end else begin
					dec_valid = 1'b1;
					dec_c     = (byte_s1 == CHAR_PLUS) ? CHAR_SPACE : byte_s1;
				end
			end
		end

		// decoded byte: length and character checks
		if (dec_valid) begin
			case (active_field_q)
				FIELD_ERROR: len_full = err_len_q >= ERR_LW'(ERROR_MAX_LEN);
				FIELD_CODE:  len_full = code_len_q >= CODE_LW'(CODE_MAX_LEN);
				FIELD_STATE: len_full = state_len_q >= ST_LW'(SECRET_LEN);
				default:     len_full = 1'b1;
			endcase
			if (dec_c < CHAR_SPACE || dec_c == CHAR_DEL || len_full) begin
				field_bad_d = field_bad_d | act_mask;
			end else begin
				emit       = 1'b1;
				emit_byte  = dec_c;
				emit_field = active_field_q;
				case (active_field_q)
					FIELD_ERROR: err_len_d = err_len_q + ERR_LW'(1);
					FIELD_CODE:  code_len_d = code_len_q + CODE_LW'(1);
					FIELD_STATE: begin
						state_len_d = state_len_q + ST_LW'(1);
						if (!b64url_char(dec_c)) begin
							state_chars_ok_d = 1'b0;
						end
					end
					default: ;
				endcase
			end
		end

		// final beat: verdict and return to reset state
		if (last_s1) begin
			if (pair_phase_d == PHASE_VALUE && active_field_d != FIELD_NONE &&
				esc_d != ESC_IDLE) begin
				field_bad_d = field_bad_d | (3'b001 << active_field_d);
			end
			code_ok  = field_found_d[FIELD_CODE] && !field_bad_d[FIELD_CODE] &&
				code_len_d != '0;
			state_ok = field_found_d[FIELD_STATE] && !field_bad_d[FIELD_STATE] &&
				state_len_d == ST_LW'(SECRET_LEN) && state_chars_ok_d;
			if (field_found_d[FIELD_ERROR]) begin
				status_d = STATUS_IDP;
				usable_d = !field_bad_d[FIELD_ERROR] && err_len_d != '0;
			end else begin
				status_d = (code_ok && state_ok) ? STATUS_OK : STATUS_INVALID;
			end
			pair_phase_d     = PHASE_KEY;
			key_pos_d        = '0;
			key_match_d      = 3'b111;
			active_field_d   = FIELD_NONE;
			esc_d            = ESC_IDLE;
			high_nibble_d    = '0;
			field_found_d    = '0;
			field_bad_d      = '0;
			err_len_d        = '0;
			code_len_d       = '0;
			state_len_d      = '0;
			state_chars_ok_d = 1'b1;
		end

		has_result = emit || last_s1;
	end

	// parse state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pair_phase_q     <= PHASE_KEY;
			key_pos_q        <= '0;
			key_match_q      <= 3'b111;
			active_field_q   <= FIELD_NONE;
			esc_q            <= ESC_IDLE;
			high_nibble_q    <= '0;
			field_found_q    <= '0;
			field_bad_q      <= '0;
			err_len_q        <= '0;
			code_len_q       <= '0;
			state_len_q      <= '0;
			state_chars_ok_q <= 1'b1;
		end else if (advance) begin
			pair_phase_q     <= pair_phase_d;
			key_pos_q        <= key_pos_d;
			key_match_q      <= key_match_d;
			active_field_q   <= active_field_d;
			esc_q            <= esc_d;
			high_nibble_q    <= high_nibble_d;
			field_found_q    <= field_found_d;
			field_bad_q      <= field_bad_d;
			err_len_q        <= err_len_d;
			code_len_q       <= code_len_d;
			state_len_q      <= state_len_d;
			state_chars_ok_q <= state_chars_ok_d;
		end
	end

	// result register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= has_result;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// result register payload
	always_ff @(posedge clk) begin
		if (advance && has_result) begin
			value_valid_q <= emit;
			value_byte_q  <= emit_byte;
			value_field_q <= emit_field;
			done_q        <= last_s1;
			status_q      <= status_d;
			usable_q      <= usable_d;
		end
	end

	assign out_ch.valid             = out_valid_q;
	assign out_ch.value_valid       = value_valid_q;
	assign out_ch.value_byte        = value_byte_q;
	assign out_ch.value_field       = value_field_q;
	assign out_ch.done_res          = done_q;
	assign out_ch.status            = status_q;
	assign out_ch.error_text_usable = usable_q;

	// every result beat carries a byte or a verdict
	a_result_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid |-> (out_ch.value_valid || out_ch.done_res))
		else $error("result beat with neither byte nor verdict");

	// verdict fields quiet on non-final beats
	a_status_only_done: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && !out_ch.done_res |->
			out_ch.status == STATUS_OK && !out_ch.error_text_usable)
		else $error("status set on a non-final beat");

	// usable error text only with an identity provider error
	a_usable_idp: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && out_ch.error_text_usable |-> out_ch.status == STATUS_IDP)
		else $error("error text usable without idp status");

	// input stage holds its beat while the result register is stalled
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && out_valid_q && !out_ch.ready |=> valid_s1 && $stable(byte_s1))
		else $error("input stage beat lost under stall");

	// parse state returns to reset after the final beat
	a_reset_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		advance && last_s1 |=>
			pair_phase_q == PHASE_KEY && field_found_q == 3'b000 && field_bad_q == 3'b000)
		else $error("parse state not cleared after final beat");

endmodule

// ===== dv/tb_callback_query_field_parser.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_callback_query_field_parser
// Self-checking bench for the callback query parser. Query strings are queued
// as beats (directed corner cases first, then random well-formed logins,
// error replies, mixed pairs and raw noise). A clocked driver sends them in
// bursts with random gaps; every accepted beat runs through a behavioral
// parser in the bench that queues the expected decoded byte or verdict. A
// clocked monitor stalls on its own pattern, holds off once for a long
// stretch, and compares every result field against the oldest expectation.
// ----------------------------------------------------------------------------
module tb_callback_query_field_parser;
	import cqfp_pkg::*;

	localparam int CODE_MAX_LEN  = 1024;
	localparam int ERROR_MAX_LEN = 128;
	localparam int SECRET_LEN    = 43;

	localparam int RANDOM_BEATS = 400;
	localparam int DRAIN_CYCLES = 8;
	localparam int HOLD_AT      = 200;
	localparam int HOLD_CYCLES  = 400;
	localparam int CYCLE_LIMIT  = 500000;

	typedef struct packed {
		logic [7:0] b;
		logic       present;
		logic       last_flag;
	} query_beat_t;

	typedef struct packed {
		logic       value_valid;
		logic [7:0] value_byte;
		logic [1:0] value_field;
		logic       done_res;
		logic [1:0] status;
		logic       error_text_usable;
	} parse_result_t;

	typedef enum {VAL_B64, VAL_TEXT, VAL_NOISY} value_style_t;
	typedef enum {PAIR_CODE, PAIR_STATE, PAIR_EXTRA, PAIR_ERROR} pair_kind_t;
	typedef enum {RX_ALWAYS, RX_COIN, RX_THREE_IN_FOUR, RX_SPARSE} rx_mode_t;

	logic clk = 1'b0;
	logic arst_n;

	cqfp_in_if  in_bus();
	cqfp_out_if out_bus();

	callback_query_field_parser #(
		.CODE_MAX_LEN (CODE_MAX_LEN),
		.ERROR_MAX_LEN(ERROR_MAX_LEN),
		.SECRET_LEN   (SECRET_LEN)
	) i_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.in_ch (in_bus),
		.out_ch(out_bus)
	);

	// clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	query_beat_t   query_beats[$];
	parse_result_t expected_results[$];
	logic [7:0]    qry_bytes[$];
	string         key_pool[11] = '{"error", "code", "state", "err", "codes", "stat",
		"states", "cod", "Code", "redirect", ""};

	int err_count    = 0;
	int cycle_count  = 0;
	int burst_left   = 1;
	int gap_left     = 0;
	int results_seen = 0;
	int rx_cycle     = 0;
	int hold_left    = 0;
	bit hold_done    = 1'b0;
	query_beat_t   next_beat;
	parse_result_t want;

	// parser state of the bench
	logic [1:0] qp_phase;
	logic [2:0] qp_key_pos;
	logic [2:0] qp_key_hits;
	logic [1:0] qp_field;
	logic [1:0] qp_esc;
	logic [3:0] qp_hi_nib;
	logic [2:0] qp_found;
	logic [2:0] qp_bad;
	int         qp_len[3];
	logic       qp_state_b64;

	task automatic report_error(input string msg);
		err_count++;
		$display("mismatch at %0t: %s", $time, msg);
	endtask

	function automatic int key_length(input int k);
		case (k)
			FIELD_CODE: return 4;
			default:    return 5;
		endcase
	endfunction

	function automatic logic [7:0] key_letter(input int k, input int pos);
		string txt;
		case (k)
			FIELD_ERROR: txt = "error";
			FIELD_CODE:  txt = "code";
			default:     txt = "state";
		endcase
		return txt[pos];
	endfunction

	function automatic logic [4:0] nibble_of(input logic [7:0] c);
		if (c >= 8'h30 && c <= 8'h39) return 5'(c - 8'h30);
		if (c >= 8'h41 && c <= 8'h46) return 5'(c - 8'h37);
		if (c >= 8'h61 && c <= 8'h66) return 5'(c - 8'h57);
		return 5'd16;
	endfunction

	function automatic bit is_b64url(input logic [7:0] c);
		return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A) ||
			(c >= 8'h30 && c <= 8'h39) || c == 8'h2D || c == 8'h5F;
	endfunction

	function automatic int value_limit(input logic [1:0] f);
		case (f)
			FIELD_ERROR: return ERROR_MAX_LEN;
			FIELD_CODE:  return CODE_MAX_LEN;
			default:     return SECRET_LEN;
		endcase
	endfunction

	// count a decoded byte against its field, 1 if it goes out
	function automatic bit take_value_byte(input logic [1:0] f, input logic [7:0] c);
		if (c < CHAR_SPACE || c == CHAR_DEL || qp_len[f] >= value_limit(f)) begin
			qp_bad[f] = 1'b1;
			return 1'b0;
		end
		qp_len[f]++;
		if (f == FIELD_STATE && !is_b64url(c)) qp_state_b64 = 1'b0;
		return 1'b1;
	endfunction

	task automatic open_pair();
		qp_phase    = PHASE_KEY;
		qp_key_pos  = '0;
		qp_key_hits = 3'b111;
		qp_field    = FIELD_NONE;
		qp_esc      = ESC_IDLE;
		qp_hi_nib   = '0;
	endtask

	task automatic clear_query();
		open_pair();
		qp_found     = '0;
		qp_bad       = '0;
		qp_len       = '{0, 0, 0};
		qp_state_b64 = 1'b1;
	endtask

	// advance the bench parser by one beat and queue what it produces
	task automatic predict_beat(input logic [7:0] b, input logic present, input logic last_flag);
		parse_result_t r;
		logic [1:0]    f;
		logic [4:0]    nib;
		logic [7:0]    c;
		bit            code_ok;
		bit            state_ok;
		r = '0;
		if (present) begin
			if (b == CHAR_AMP) begin
				if (qp_phase == PHASE_VALUE && qp_field != FIELD_NONE && qp_esc != ESC_IDLE)
					qp_bad[qp_field] = 1'b1;
				open_pair();
			end else if (qp_phase == PHASE_KEY) begin
				if (b == CHAR_EQ) begin
					f = FIELD_NONE;
					for (int k = 0; k < 3; k++)
						if (qp_key_hits[k] && qp_key_pos == key_length(k)) f = 2'(k);
					if (f != FIELD_NONE) begin
						if (qp_found[f]) qp_bad[f] = 1'b1;
						qp_found[f] = 1'b1;
					end
					qp_field = f;
					qp_phase = PHASE_VALUE;
					qp_esc   = ESC_IDLE;
				end else begin
					for (int k = 0; k < 3; k++)
						if (qp_key_pos >= key_length(k) || key_letter(k, qp_key_pos) != b)
							qp_key_hits[k] = 1'b0;
					if (qp_key_pos != KEY_POS_MAX) qp_key_pos++;
				end
			end else if (qp_field != FIELD_NONE && !qp_bad[qp_field]) begin
				f = qp_field;
				case (qp_esc)
					ESC_HIGH: begin
						nib = nibble_of(b);
						if (nib[4]) begin
							qp_bad[f] = 1'b1;
							qp_esc = ESC_IDLE;
						end else begin
							qp_hi_nib = nib[3:0];
							qp_esc = ESC_LOW;
						end
					end
					ESC_LOW: begin
						nib = nibble_of(b);
						qp_esc = ESC_IDLE;
						if (nib[4]) begin
							qp_bad[f] = 1'b1;
						end else begin
							c = {qp_hi_nib, nib[3:0]};
							r.value_valid = take_value_byte(f, c);
							r.value_byte  = c;
							r.value_field = f;
						end
					end
					default: begin
						if (b == CHAR_PERCENT) begin
							qp_esc = ESC_HIGH;
						end else begin
							c = (b == CHAR_PLUS) ? CHAR_SPACE : b;
							r.value_valid = take_value_byte(f, c);
							r.value_byte  = c;
							r.value_field = f;
						end
					end
				endcase
				if (!r.value_valid) begin
					r.value_byte  = '0;
					r.value_field = '0;
				end
			end
		end
		// verdict on the final beat, then back to a fresh query
		if (last_flag) begin
			if (qp_phase == PHASE_VALUE && qp_field != FIELD_NONE && qp_esc != ESC_IDLE)
				qp_bad[qp_field] = 1'b1;
			r.done_res = 1'b1;
			if (qp_found[FIELD_ERROR]) begin
				r.status = STATUS_IDP;
				r.error_text_usable = !qp_bad[FIELD_ERROR] && qp_len[FIELD_ERROR] > 0;
			end else begin
				code_ok = qp_found[FIELD_CODE] && !qp_bad[FIELD_CODE] && qp_len[FIELD_CODE] > 0;
				state_ok = qp_found[FIELD_STATE] && !qp_bad[FIELD_STATE] &&
					qp_len[FIELD_STATE] == SECRET_LEN && qp_state_b64;
				r.status = (code_ok && state_ok) ? STATUS_OK : STATUS_INVALID;
			end
			clear_query();
		end
		if (r.value_valid || r.done_res) expected_results.push_back(r);
	endtask

	// query building
	task automatic push_beat(input logic [7:0] b, input logic present, input logic last_flag);
		query_beats.push_back('{b, present, last_flag});
	endtask

	task automatic add_str(input string s);
		for (int i = 0; i < s.len(); i++) qry_bytes.push_back(s[i]);
	endtask

	task automatic add_sep();
		if (qry_bytes.size() != 0) qry_bytes.push_back(CHAR_AMP);
	endtask

	function automatic logic [7:0] rand_b64();
		int r;
		r = $urandom_range(0, 63);
		if (r < 26) return 8'(8'h41 + r);
		if (r < 52) return 8'(8'h61 + r - 26);
		if (r < 62) return 8'(8'h30 + r - 52);
		return (r == 62) ? 8'h2D : 8'h5F;
	endfunction

	function automatic logic [7:0] hex_char(input logic [3:0] n);
		if (n < 10) return 8'(8'h30 + n);
		return 8'(($urandom_range(0, 1) ? 8'h61 : 8'h41) + n - 10);
	endfunction

	task automatic add_escape(input logic [7:0] v);
		qry_bytes.push_back(CHAR_PERCENT);
		qry_bytes.push_back(hex_char(v[7:4]));
		qry_bytes.push_back(hex_char(v[3:0]));
	endtask

	task automatic add_value(input value_style_t style, input int len);
		int r;
		logic [7:0] v;
		for (int i = 0; i < len; i++) begin
			r = $urandom_range(0, 99);
			case (style)
				VAL_B64: qry_bytes.push_back(rand_b64());
				VAL_TEXT: begin
					if (r < 70) begin
						qry_bytes.push_back(rand_b64());
					end else if (r < 80) begin
						qry_bytes.push_back(CHAR_PLUS);
					end else if (r < 95) begin
						v = 8'($urandom_range(8'h20, 8'hFF));
						if (v == CHAR_DEL) v = CHAR_SPACE;
						add_escape(v);
					end else begin
						v = 8'($urandom_range(8'h21, 8'h7E));
						if (v == CHAR_AMP || v == CHAR_PERCENT) v = 8'h2E;
						qry_bytes.push_back(v);
					end
				end
				default: begin
					if (r < 45) begin
						qry_bytes.push_back(rand_b64());
					end else if (r < 55) begin
						qry_bytes.push_back(CHAR_PLUS);
					end else if (r < 70) begin
						add_escape(8'($urandom_range(0, 255)));
					end else if (r < 80) begin
						// escape lead-in with any following byte, '&' included
						qry_bytes.push_back(CHAR_PERCENT);
						qry_bytes.push_back(8'($urandom_range(0, 255)));
					end else begin
						v = 8'($urandom_range(0, 255));
						if (v == CHAR_AMP) v = CHAR_DEL;
						qry_bytes.push_back(v);
					end
				end
			endcase
		end
	endtask

	// turn the built bytes into beats, some idle beats mixed in
	task automatic close_query(input bit sep_end);
		int n;
		n = qry_bytes.size();
		if (n == 0) sep_end = 1'b1;
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 31) == 0) push_beat(8'($urandom_range(0, 255)), 1'b0, 1'b0);
			push_beat(qry_bytes[i], 1'b1, !sep_end && i == n - 1);
		end
		if (sep_end) push_beat(8'($urandom_range(0, 255)), 1'b0, 1'b1);
		qry_bytes.delete();
	endtask

	// login reply or error reply, pairs in random order
	task automatic gen_login(input bit with_error);
		pair_kind_t ids[4];
		pair_kind_t t;
		int j;
		int len;
		bit use_code;
		bit use_state;
		bit use_extra;
		ids = '{PAIR_CODE, PAIR_STATE, PAIR_EXTRA, PAIR_ERROR};
		use_code  = !with_error || $urandom_range(0, 9) < 7;
		use_state = !with_error || $urandom_range(0, 9) < 7;
		use_extra = $urandom_range(0, 3) == 0;
		for (int i = 3; i > 0; i--) begin
			j = $urandom_range(0, i);
			t = ids[i];
			ids[i] = ids[j];
			ids[j] = t;
		end
		for (int i = 0; i < 4; i++) begin
			case (ids[i])
				PAIR_CODE: if (use_code) begin
					add_sep();
					add_str("code=");
					add_value(($urandom_range(0, 9) == 0) ? VAL_NOISY : VAL_TEXT,
						$urandom_range(1, 24));
				end
				PAIR_STATE: if (use_state) begin
					add_sep();
					add_str("state=");
					len = ($urandom_range(0, 4) == 0) ?
						$urandom_range(SECRET_LEN - 1, SECRET_LEN + 1) : SECRET_LEN;
					add_value(($urandom_range(0, 9) == 0) ? VAL_TEXT : VAL_B64, len);
				end
				PAIR_EXTRA: if (use_extra) begin
					add_sep();
					add_str("lang=");
					add_value(VAL_B64, $urandom_range(0, 6));
				end
				default: if (with_error) begin
					add_sep();
					add_str("error=");
					add_value(($urandom_range(0, 3) == 0) ? VAL_NOISY : VAL_TEXT,
						$urandom_range(0, 20));
				end
			endcase
		end
	endtask

	// loose pairs: near-miss keys, missing '=', duplicates, cut escapes
	task automatic gen_mixed();
		int n;
		int k;
		n = $urandom_range(1, 4);
		for (int p = 0; p < n; p++) begin
			if (qry_bytes.size() != 0 || $urandom_range(0, 9) == 0) qry_bytes.push_back(CHAR_AMP);
			k = $urandom_range(0, 11);
			if (k < 11) begin
				add_str(key_pool[k]);
			end else begin
				repeat ($urandom_range(1, 9)) qry_bytes.push_back(8'($urandom_range(0, 255)));
			end
			if ($urandom_range(0, 6) != 0) begin
				qry_bytes.push_back(CHAR_EQ);
				add_value(value_style_t'($urandom_range(0, 2)), $urandom_range(0, 12));
				if ($urandom_range(0, 9) == 0) begin
					qry_bytes.push_back(CHAR_PERCENT);
					if ($urandom_range(0, 1)) qry_bytes.push_back(hex_char(4'($urandom_range(0, 15))));
				end
			end
		end
	endtask

	task automatic gen_noise();
		int r;
		repeat ($urandom_range(0, 30)) begin
			r = $urandom_range(0, 9);
			case (r)
				0: qry_bytes.push_back(CHAR_AMP);
				1: qry_bytes.push_back(CHAR_EQ);
				2: qry_bytes.push_back(CHAR_PERCENT);
				default: qry_bytes.push_back(8'($urandom_range(0, 255)));
			endcase
		end
	endtask

	// driver: predicts on each accepted beat, sends in bursts with gaps
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_bus.valid        <= 1'b0;
			in_bus.in_byte      <= '0;
			in_bus.byte_present <= 1'b0;
			in_bus.last_byte    <= 1'b0;
		end else begin
			if (in_bus.valid && in_bus.ready)
				predict_beat(in_bus.in_byte, in_bus.byte_present, in_bus.last_byte);
			// an offered beat stays until taken
			if (!in_bus.valid || in_bus.ready) begin
				if (gap_left != 0 || query_beats.size() == 0) begin
					if (gap_left != 0) gap_left--;
					in_bus.valid <= 1'b0;
				end else begin
					next_beat = query_beats.pop_front();
					in_bus.valid        <= 1'b1;
					in_bus.in_byte      <= next_beat.b;
					in_bus.byte_present <= next_beat.present;
					in_bus.last_byte    <= next_beat.last_flag;
					burst_left--;
					if (burst_left <= 0) begin
						burst_left = $urandom_range(1, 48);
						gap_left = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 8) : 0;
					end
				end
			end
		end
	end

	// monitor: compare each result beat, then pick the next ready
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_bus.ready <= 1'b0;
		end else begin
			if (out_bus.valid && out_bus.ready) begin
				results_seen++;
				if (expected_results.size() == 0) begin
					report_error($sformatf("result with nothing expected: byte %02h field %0d done %0b",
						out_bus.value_byte, out_bus.value_field, out_bus.done_res));
				end else begin
					want = expected_results.pop_front();
					if (out_bus.value_valid !== want.value_valid)
						report_error($sformatf("value_valid %b, expected %b",
							out_bus.value_valid, want.value_valid));
					if (out_bus.value_byte !== want.value_byte)
						report_error($sformatf("value_byte %02h, expected %02h",
							out_bus.value_byte, want.value_byte));
					if (out_bus.value_field !== want.value_field)
						report_error($sformatf("value_field %0d, expected %0d",
							out_bus.value_field, want.value_field));
					if (out_bus.done_res !== want.done_res)
						report_error($sformatf("done_res %b, expected %b",
							out_bus.done_res, want.done_res));
					if (out_bus.status !== want.status)
						report_error($sformatf("status %0d, expected %0d",
							out_bus.status, want.status));
					if (out_bus.error_text_usable !== want.error_text_usable)
						report_error($sformatf("error_text_usable %b, expected %b",
							out_bus.error_text_usable, want.error_text_usable));
				end
			end
			// stall pattern, plus one long hold-off to back up the input
			rx_cycle++;
			if (results_seen >= HOLD_AT && !hold_done) begin
				hold_left = HOLD_CYCLES;
				hold_done = 1'b1;
			end
			if (hold_left != 0) begin
				hold_left--;
				out_bus.ready <= 1'b0;
			end else begin
				case (rx_mode_t'((rx_cycle / 256) % 4))
					RX_ALWAYS:        out_bus.ready <= 1'b1;
					RX_COIN:          out_bus.ready <= 1'($urandom_range(0, 1));
					RX_THREE_IN_FOUR: out_bus.ready <= (rx_cycle % 4) != 0;
					default:          out_bus.ready <= $urandom_range(0, 3) == 0;
				endcase
			end
		end
	end

	// run limit
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	initial begin
		int random_goal;
		int r;
		arst_n              = 1'b0;
		in_bus.valid        = 1'b0;
		in_bus.in_byte      = '0;
		in_bus.byte_present = 1'b0;
		in_bus.last_byte    = 1'b0;
		out_bus.ready       = 1'b0;
		clear_query();

		// empty query
		close_query(1'b1);
		// clean login with '+' and an escape
		add_str("code=a%41+b&state=");
		add_value(VAL_B64, SECRET_LEN);
		close_query(1'b0);
		// error wins over a clean login
		add_str("error=access_denied&code=x&state=");
		add_value(VAL_B64, SECRET_LEN);
		close_query(1'b0);
		// empty error text
		add_str("error=");
		close_query(1'b0);
		// duplicate key
		add_str("code=1&code=2");
		close_query(1'b0);
		// non-hex escape, escape cut by end, escape cut by '&'
		add_str("error=%zz");
		close_query(1'b0);
		add_str("error=%4");
		close_query(1'b1);
		add_str("code=%4&state=x");
		close_query(1'b0);
		// control bytes through escapes
		add_str("error=%00%7f");
		close_query(1'b0);
		// zero byte in a key, zero and high bytes in a value
		qry_bytes.push_back(8'h00);
		add_str("code=1");
		close_query(1'b0);
		add_str("code=");
		qry_bytes.push_back(8'hFF);
		qry_bytes.push_back(8'h00);
		qry_bytes.push_back(CHAR_DEL);
		close_query(1'b0);
		// long key, key without '=', empty key, wrong case
		add_str("aaaaaaaaaa=1&statexyz=2&code&=z&Code=3");
		close_query(1'b0);
		// error text one past its maximum length
		add_str("error=");
		add_value(VAL_B64, ERROR_MAX_LEN + 1);
		close_query(1'b0);
		// state through an escape, and state with a non-base64url byte
		add_str("code=q&state=%2D");
		add_value(VAL_B64, SECRET_LEN - 1);
		close_query(1'b0);
		add_str("state=.");
		add_value(VAL_B64, SECRET_LEN - 1);
		add_str("&code=q");
		close_query(1'b0);

		// random queries
		random_goal = query_beats.size() + RANDOM_BEATS;
		while (query_beats.size() < random_goal) begin
			r = $urandom_range(0, 99);
			if (r < 40) gen_login(1'b0);
			else if (r < 55) gen_login(1'b1);
			else if (r < 85) gen_mixed();
			else gen_noise();
			close_query($urandom_range(0, 9) == 0);
		end

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (query_beats.size() != 0 || in_bus.valid) @(posedge clk);
		while (expected_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (err_count == 0 && expected_results.size() == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
src/cqfp_pkg.sv
src/cqfp_in_if.sv
src/cqfp_out_if.sv
src/callback_query_field_parser.sv
dv/tb_callback_query_field_parser.sv
